### design/ssop_pkg.sv
// ssop_pkg: shared widths, codes and types of the segment offset planner.
// Used by the channel interfaces and by every module of the block.
package ssop_pkg;

    // Field widths
    localparam int FRAME_ADDR_BITS  = 26;
    localparam int SEGMENT_BITS     = 14;
    localparam int INDEX_BITS       = 16;
    localparam int STATUS_BITS      = 3;
    localparam int FINAL_INDEX_BITS = FRAME_ADDR_BITS + 1;

    // Packets numbered 1..LEARN_WINDOW may teach the segment size
    localparam int LEARN_WINDOW = 5;

    // Serial unit step counters
    localparam int MUL_CNT_BITS = $clog2(INDEX_BITS);
    localparam int DIV_CNT_BITS = $clog2(FRAME_ADDR_BITS);

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_BLOCK = 3'd0,
        STAT_ZERO  = 3'd1,
        STAT_LEARN = 3'd2,
        STAT_STD   = 3'd3,
        STAT_LAST  = 3'd4,
        STAT_REJ   = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### design/ssop_if.sv
// ssop_if: valid/ready channel interfaces of the segment offset planner.
// Depends on ssop_pkg for field widths.

// Configuration write channel: frame size register
interface ssop_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0] frame_bytes;

    modport source (output valid, output frame_bytes, input ready);
    modport sink   (input valid, input frame_bytes, output ready);
endinterface

// Segment header channel
interface ssop_hdr_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [ssop_pkg::INDEX_BITS-1:0]   segment_index;
    logic [ssop_pkg::SEGMENT_BITS-1:0] segment_bytes;

    modport source (output valid, output kind, output segment_index,
                    output segment_bytes, input ready);
    modport sink   (input valid, input kind, input segment_index,
                    input segment_bytes, output ready);
endinterface

// Copy plan result channel
interface ssop_plan_if;
    logic                                 valid;
    logic                                 ready;
    logic [ssop_pkg::STATUS_BITS-1:0]     status;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0] write_offset;
    logic [ssop_pkg::SEGMENT_BITS-1:0]    copy_bytes;

    modport source (output valid, output status, output write_offset,
                    output copy_bytes, input ready);
    modport sink   (input valid, input status, input write_offset,
                    input copy_bytes, output ready);
endinterface

### design/ssop_mul.sv
// ssop_mul: shift-add multiplier, one multiplier bit per cycle.
// Gives (index - 1) times segment size modulo the frame address width.
// Depends on ssop_pkg.
module ssop_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ssop_pkg::INDEX_BITS-1:0]      multiplier,
    input  logic [ssop_pkg::SEGMENT_BITS-1:0]    multiplicand,
    output logic                                 done,
    output logic [ssop_pkg::FRAME_ADDR_BITS-1:0] product
);

    logic [ssop_pkg::INDEX_BITS-1:0]      mplier_reg, mplier_next;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0] mcand_reg, mcand_next;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0] acc_reg, acc_next;
    logic [ssop_pkg::MUL_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;

    // One partial product per cycle, multiplier consumed LSB first
    always_comb
    begin
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mplier_next = multiplier;
            mcand_next  = ssop_pkg::FRAME_ADDR_BITS'(multiplicand);
            acc_next    = '0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[ssop_pkg::FRAME_ADDR_BITS-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[ssop_pkg::INDEX_BITS-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == ssop_pkg::MUL_CNT_BITS'(ssop_pkg::INDEX_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### design/ssop_div.sv
// ssop_div: restoring divider, one quotient bit per cycle.
// Divides the frame size by the learned segment size. Depends on ssop_pkg.
module ssop_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ssop_pkg::FRAME_ADDR_BITS-1:0] dividend,
    input  logic [ssop_pkg::SEGMENT_BITS-1:0]    divisor,
    output logic                                 done,
    output logic [ssop_pkg::FRAME_ADDR_BITS-1:0] quotient,
    output logic [ssop_pkg::SEGMENT_BITS-1:0]    remainder
);

    logic [ssop_pkg::FRAME_ADDR_BITS-1:0] quo_reg, quo_next;
    logic [ssop_pkg::SEGMENT_BITS-1:0]    rem_reg, rem_next;
    logic [ssop_pkg::SEGMENT_BITS-1:0]    dvs_reg, dvs_next;
    logic [ssop_pkg::DIV_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic [ssop_pkg::SEGMENT_BITS:0]      trial;
    logic [ssop_pkg::SEGMENT_BITS:0]      diff;

    // Partial remainder stays below the divisor, so trial fits one extra bit
    assign trial = {rem_reg, quo_reg[ssop_pkg::FRAME_ADDR_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    // Dividend shifts out the top as quotient bits shift in the bottom
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[ssop_pkg::SEGMENT_BITS])
            begin
                rem_next = diff[ssop_pkg::SEGMENT_BITS-1:0];
            end
            else
            begin
                rem_next = trial[ssop_pkg::SEGMENT_BITS-1:0];
            end
            quo_next = {quo_reg[ssop_pkg::FRAME_ADDR_BITS-2:0],
                        ~diff[ssop_pkg::SEGMENT_BITS]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ssop_pkg::DIV_CNT_BITS'(ssop_pkg::FRAME_ADDR_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### design/stream_segment_offset_planner.sv
// stream_segment_offset_planner: top level, header decode, sequencer and result register.
// Block start, index zero and zero-size learning items go from idle straight to the done state;
//   other items run the 16-step serial multiply, and an item that learns also the 26-step divide.
// One item at a time, taken only in idle; the next item is taken while a result waits.
// Reset (rst_n, async low): frame size 0, nothing learned, final index 1, output empty.
// Depends on ssop_pkg, ssop_if, ssop_mul and ssop_div.
module stream_segment_offset_planner (
    input  logic               clk,
    input  logic               rst_n,
    ssop_cfg_if.sink           cfg,
    ssop_hdr_if.sink           hdr,
    ssop_plan_if.source        plan
);

    ssop_pkg::state_t state_reg, state_next;

    // Register and learned state
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0]  frame_bytes_reg, frame_bytes_next;
    logic [ssop_pkg::SEGMENT_BITS-1:0]     learned_reg, learned_next;
    logic [ssop_pkg::FINAL_INDEX_BITS-1:0] final_index_reg, final_index_next;
    logic [ssop_pkg::SEGMENT_BITS-1:0]     final_seg_reg, final_seg_next;

    // Item in work
    logic [ssop_pkg::INDEX_BITS-1:0]       idx_reg, idx_next;
    logic [ssop_pkg::SEGMENT_BITS-1:0]     bytes_reg, bytes_next;
    logic                                  learn_reg, learn_next;

    // Result being built
    ssop_pkg::status_t                     res_status_reg, res_status_next;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0]  res_offset_reg, res_offset_next;
    logic [ssop_pkg::SEGMENT_BITS-1:0]     res_copy_reg, res_copy_next;

    // Output register
    logic                                  out_valid_reg, out_valid_next;
    ssop_pkg::status_t                     out_status_reg;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0]  out_offset_reg;
    logic [ssop_pkg::SEGMENT_BITS-1:0]     out_copy_reg;

    logic                                  accept;
    logic                                  learn_hit;
    logic                                  quick;
    logic                                  out_free;
    logic                                  out_load;
    logic                                  mul_start;
    logic                                  mul_done;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0]  product;
    logic                                  div_start;
    logic                                  div_done;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0]  quotient;
    logic [ssop_pkg::SEGMENT_BITS-1:0]     remainder;
    logic                                  off_ok;
    logic [ssop_pkg::FRAME_ADDR_BITS-1:0]  room;
    logic [ssop_pkg::SEGMENT_BITS-1:0]     learn_count;
    logic [ssop_pkg::FINAL_INDEX_BITS-1:0] idx_ext;
    logic                                  std_hit;
    logic                                  last_hit;

    // Header decode at acceptance
    assign accept    = hdr.valid && hdr.ready;
    assign learn_hit = (hdr.segment_index <= ssop_pkg::INDEX_BITS'(ssop_pkg::LEARN_WINDOW))
                       && (learned_reg == '0);
    assign quick     = hdr.kind || (hdr.segment_index == '0)
                       || (learn_hit && (hdr.segment_bytes == '0));
    assign out_free  = !out_valid_reg || plan.ready;

    // Offset multiply: (index - 1) times size
    ssop_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplier   (hdr.segment_index - 1'b1),
        .multiplicand (learn_hit ? hdr.segment_bytes : learned_reg),
        .done         (mul_done),
        .product      (product)
    );

    // Final index divide: frame size by learned size
    ssop_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (frame_bytes_reg),
        .divisor   (bytes_reg),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Checks on the product
    assign off_ok      = product < frame_bytes_reg;
    assign room        = frame_bytes_reg - product;
    assign learn_count = (ssop_pkg::FRAME_ADDR_BITS'(bytes_reg) < room)
                         ? bytes_reg : room[ssop_pkg::SEGMENT_BITS-1:0];
    assign idx_ext     = ssop_pkg::FINAL_INDEX_BITS'(idx_reg);
    assign std_hit     = (idx_ext < final_index_reg) && (bytes_reg == learned_reg);
    assign last_hit    = (idx_ext == final_index_reg) && (bytes_reg <= learned_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssop_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = quick ? ssop_pkg::ST_DONE : ssop_pkg::ST_MUL;
                end
            end
            ssop_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ssop_pkg::ST_EVAL;
                end
            end
            ssop_pkg::ST_EVAL:
            begin
                state_next = (learn_reg && off_ok) ? ssop_pkg::ST_DIV : ssop_pkg::ST_DONE;
            end
            ssop_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ssop_pkg::ST_DONE;
                end
            end
            ssop_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ssop_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssop_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        hdr.ready = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ssop_pkg::ST_IDLE:
            begin
                hdr.ready = 1'b1;
                mul_start = hdr.valid && !quick;
            end
            ssop_pkg::ST_EVAL:
            begin
                div_start = learn_reg && off_ok;
            end
            ssop_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        frame_bytes_next = frame_bytes_reg;
        learned_next     = learned_reg;
        final_index_next = final_index_reg;
        final_seg_next   = final_seg_reg;
        idx_next         = idx_reg;
        bytes_next       = bytes_reg;
        learn_next       = learn_reg;
        res_status_next  = res_status_reg;
        res_offset_next  = res_offset_reg;
        res_copy_next    = res_copy_reg;

        // frame size write
        if (cfg.valid && cfg.ready)
        begin
            frame_bytes_next = cfg.frame_bytes;
        end

        // latch header and settle the cases that need no arithmetic
        if (accept)
        begin
            idx_next        = hdr.segment_index;
            bytes_next      = hdr.segment_bytes;
            learn_next      = learn_hit;
            res_offset_next = '0;
            res_copy_next   = '0;
            if (hdr.kind)
            begin
                res_status_next  = ssop_pkg::STAT_BLOCK;
                learned_next     = '0;
                final_index_next = ssop_pkg::FINAL_INDEX_BITS'(1);
                final_seg_next   = '0;
            end
            else if (hdr.segment_index == '0)
            begin
                res_status_next = ssop_pkg::STAT_ZERO;
            end
            else
            begin
                res_status_next = ssop_pkg::STAT_REJ;
            end
        end

        // classify once the offset is known
        if (state_reg == ssop_pkg::ST_EVAL)
        begin
            if (learn_reg)
            begin
                if (off_ok)
                begin
                    res_status_next = ssop_pkg::STAT_LEARN;
                    res_offset_next = product;
                    res_copy_next   = learn_count;
                end
            end
            else if (std_hit)
            begin
                res_status_next = ssop_pkg::STAT_STD;
                res_offset_next = product;
                res_copy_next   = learned_reg;
            end
            else if (last_hit)
            begin
                res_status_next = ssop_pkg::STAT_LAST;
                res_offset_next = product;
                res_copy_next   = final_seg_reg;
            end
        end

        // learn size, final index and final length
        if (state_reg == ssop_pkg::ST_DIV && div_done)
        begin
            learned_next     = bytes_reg;
            final_index_next = ssop_pkg::FINAL_INDEX_BITS'(quotient)
                               + ssop_pkg::FINAL_INDEX_BITS'(remainder != '0);
            final_seg_next   = (remainder == '0) ? bytes_reg : remainder;
        end
    end

    // Output valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (plan.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and learned state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ssop_pkg::ST_IDLE;
            frame_bytes_reg <= '0;
            learned_reg     <= '0;
            final_index_reg <= ssop_pkg::FINAL_INDEX_BITS'(1);
            final_seg_reg   <= '0;
            learn_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frame_bytes_reg <= frame_bytes_next;
            learned_reg     <= learned_next;
            final_index_reg <= final_index_next;
            final_seg_reg   <= final_seg_next;
            learn_reg       <= learn_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        bytes_reg      <= bytes_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_copy_reg   <= res_copy_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_offset_reg <= res_offset_reg;
            out_copy_reg   <= res_copy_reg;
        end
    end

    assign cfg.ready         = 1'b1;
    assign plan.valid        = out_valid_reg;
    assign plan.status       = out_status_reg;
    assign plan.write_offset = out_offset_reg;
    assign plan.copy_bytes   = out_copy_reg;

`ifndef SYNTHESIS
    // accepted segments always copy something
    assert property (@(posedge clk) disable iff (!rst_n)
        plan.valid && (plan.status == ssop_pkg::STAT_LEARN
                       || plan.status == ssop_pkg::STAT_STD
                       || plan.status == ssop_pkg::STAT_LAST)
        |-> plan.copy_bytes != '0)
        else $error("accepted segment with zero copy length");

    // non-accepted results carry no offset and no length
    assert property (@(posedge clk) disable iff (!rst_n)
        plan.valid && (plan.status == ssop_pkg::STAT_BLOCK
                       || plan.status == ssop_pkg::STAT_ZERO
                       || plan.status == ssop_pkg::STAT_REJ)
        |-> plan.write_offset == '0 && plan.copy_bytes == '0)
        else $error("non-accepted result with offset or length");

    // unlearned size means the reset final index and length
    assert property (@(posedge clk) disable iff (!rst_n)
        learned_reg == '0
        |-> final_index_reg == ssop_pkg::FINAL_INDEX_BITS'(1) && final_seg_reg == '0)
        else $error("final segment state without learned size");

    // multiplier finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ssop_pkg::ST_MUL)
        else $error("multiplier done outside multiply state");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ssop_pkg::ST_DIV)
        else $error("divider done outside divide state");
`endif

endmodule
